// ===== sv/ctb_pkg.sv =====
package ctb_pkg;

  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChXLower = 8'h78;
  localparam logic [7:0] ChXUpper = 8'h58;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChALower = 8'h61;
  localparam logic [7:0] ChFLower = 8'h66;
  localparam logic [7:0] ChAUpper = 8'h41;
  localparam logic [7:0] ChFUpper = 8'h46;
  localparam logic [3:0] HexTen   = 4'd10;

  localparam logic [2:0] PosFirst  = 3'd0;
  localparam logic [2:0] PosSecond = 3'd1;
  localparam logic [2:0] PosThird  = 3'd2;
  localparam logic [2:0] PosFourth = 3'd3;
  localparam logic [2:0] PosMax    = 3'd7;

  typedef struct packed {
    logic [2:0] pos;
    logic       first_zero;
    logic       hex_prefix;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       lo_present;
    logic [7:0] acc;
    logic       dec_stopped;
  } ctb_run_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] value;
  } ctb_result_t;

  typedef struct packed {
    logic inside_body;
    logic run_open;
  } ctb_status_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] res;
    res = '0;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
      res = {1'b1, d[3:0]};
    end else if (c >= ChALower && c <= ChFLower) begin
      d = c - ChALower;
      res = {1'b1, d[3:0] + HexTen};
    end else if (c >= ChAUpper && c <= ChFUpper) begin
      d = c - ChAUpper;
      res = {1'b1, d[3:0] + HexTen};
    end
    return res;
  endfunction

  function automatic logic [7:0] run_value(input ctb_run_t r);
    logic [7:0] res;
    res = r.acc;
    if (r.hex_prefix) begin
      if (r.pos > PosFourth && r.lo_present) begin
        res = {r.hi, r.lo};
      end else if (r.pos > PosThird) begin
        res = {4'd0, r.hi};
      end else begin
        res = '0;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/ctb_decoder.sv =====
module ctb_decoder import ctb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  text_char,
  input  logic        end_of_text,
  output ctb_result_t result,
  output ctb_status_t status
);

  logic       body_r, body_nxt;
  ctb_run_t   run_r, run_nxt, added;
  logic [4:0] hd;
  logic       is_run, is_dec;
  logic [7:0] dec_digit;

  always_comb begin
    hd        = hex_digit(text_char);
    is_run    = hd[4] || text_char == ChXLower || text_char == ChXUpper;
    is_dec    = text_char >= ChZero && text_char <= ChNine;
    dec_digit = text_char - ChZero;

    added = run_r;
    case (run_r.pos)
      PosFirst:  added.first_zero = (text_char == ChZero);
      PosSecond: added.hex_prefix = run_r.first_zero &&
                                    (text_char == ChXLower || text_char == ChXUpper);
      PosThird:  added.hi = hd[3:0];
      PosFourth: begin
        added.lo         = hd[3:0];
        added.lo_present = hd[4];
      end
      default: ;
    endcase
    if (!run_r.dec_stopped) begin
      if (is_dec) begin
        added.acc = {run_r.acc[4:0], 3'b000} + {run_r.acc[6:0], 1'b0} + dec_digit;
      end else begin
        added.dec_stopped = 1'b1;
      end
    end
    if (run_r.pos != PosMax) begin
      added.pos = run_r.pos + 3'd1;
    end
  end

  always_comb begin
    body_nxt = body_r;
    run_nxt  = run_r;
    result   = '0;
    if (!body_r) begin
      if (text_char == ChLbrace) begin
        body_nxt = 1'b1;
      end
    end else if (is_run) begin
      run_nxt = added;
    end else if (run_r.pos != PosFirst) begin
      result.emit  = 1'b1;
      result.value = run_value(run_r);
      run_nxt      = '0;
    end
    if (end_of_text) begin
      if (!result.emit && run_nxt.pos != PosFirst) begin
        result.emit  = 1'b1;
        result.value = run_value(run_nxt);
      end
      body_nxt = 1'b0;
      run_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_r <= 1'b0;
      run_r  <= '0;
    end else if (accept) begin
      body_r <= body_nxt;
      run_r  <= run_nxt;
    end
  end

  assign status.inside_body = body_r;
  assign status.run_open    = (run_r.pos != PosFirst);

endmodule

// ===== sv/c_array_text_to_bytes.sv =====
// Channel  Direction  Ports                                      Payload
// in_      slave      in_tvalid in_tready in_tdata in_tlast      text_char, end_of_text
// out_     master     out_tvalid out_tready out_tdata            byte_value
//
// One item per cycle unless stalled; a byte appears the cycle after its run closes.
// Run state sits in one register set, updated by the decoder in a single pass.
// Reset (rst_n low, synchronous) clears the brace flag, the run and out_tvalid.
// A held output stalls input only while out_tready is low.
module c_array_text_to_bytes import ctb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] byte_value
);

  logic        in_acc;
  ctb_result_t res;
  ctb_status_t st;
  logic        out_valid_r;
  logic [7:0]  out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ctb_decoder u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .text_char   (in_tdata),
    .end_of_text (in_tlast),
    .result      (res),
    .status      (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.emit) begin
      out_data_r <= res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> !st.inside_body && !st.run_open)
    else $error("state not cleared after last item");

  a_search_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !st.inside_body |=> !out_valid_r)
    else $error("byte emitted during brace search");

  a_run_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    st.run_open |-> st.inside_body)
    else $error("run open outside body");

endmodule

// ===== bench/c_array_text_to_bytes_test.sv =====
module c_array_text_to_bytes_test import ctb_pkg::*; ();

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;  // [7:0] text_char
  logic       in_tlast = 1'b0;  // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;        // [7:0] byte_value

  logic       body_open = 1'b0;
  logic [2:0] run_len = PosFirst;
  logic       lead_zero = 1'b0;
  logic       hex_lit = 1'b0;
  logic [3:0] hi_nib = 4'd0;
  logic [3:0] lo_nib = 4'd0;
  logic       lo_valid = 1'b0;
  logic [7:0] dec_acc = 8'd0;
  logic       dec_done = 1'b0;

  logic [7:0] expected_bytes[$];
  logic [7:0] text_buf[$];
  logic [7:0] want;
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 30;
  int         hold_left = 0;

  c_array_text_to_bytes uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChALower && c <= ChFLower) ||
           (c >= ChAUpper && c <= ChFUpper);
  endfunction

  function automatic logic is_run_char(input logic [7:0] c);
    return is_hex_char(c) || c == ChXLower || c == ChXUpper;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ChZero && c <= ChNine) v = c - ChZero;
    else if (c >= ChALower && c <= ChFLower) v = c - ChALower + 8'd10;
    else if (c >= ChAUpper && c <= ChFUpper) v = c - ChAUpper + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] literal_byte();
    if (hex_lit) begin
      if (run_len > PosFourth && lo_valid) return {hi_nib, lo_nib};
      if (run_len > PosThird) return {4'd0, hi_nib};
      return 8'd0;
    end
    return dec_acc;
  endfunction

  task automatic clear_literal();
    run_len = PosFirst;
    lead_zero = 1'b0;
    hex_lit = 1'b0;
    hi_nib = 4'd0;
    lo_nib = 4'd0;
    lo_valid = 1'b0;
    dec_acc = 8'd0;
    dec_done = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    logic emitted;
    emitted = 1'b0;
    if (!body_open) begin
      if (c == ChLbrace) body_open = 1'b1;
    end else if (is_run_char(c)) begin
      case (run_len)
        PosFirst: lead_zero = (c == ChZero);
        PosSecond: hex_lit = lead_zero && (c == ChXLower || c == ChXUpper);
        PosThird: hi_nib = nibble_of(c);
        PosFourth: begin
          lo_nib = nibble_of(c);
          lo_valid = is_hex_char(c);
        end
        default: ;
      endcase
      if (!dec_done) begin
        if (c >= ChZero && c <= ChNine) dec_acc = dec_acc * 8'd10 + (c - ChZero);
        else dec_done = 1'b1;
      end
      if (run_len != PosMax) run_len = run_len + 3'd1;
    end else if (run_len != PosFirst) begin
      expected_bytes.push_back(literal_byte());
      emitted = 1'b1;
      clear_literal();
    end
    if (last) begin
      if (!emitted && run_len != PosFirst) expected_bytes.push_back(literal_byte());
      body_open = 1'b0;
      clear_literal();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected byte_value %h", out_tdata);
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("byte_value mismatch: expected %h, got %h", want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) decode_char(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        gap = pick_gap();
        out_tready <= (gap == 0);
        if (gap > 0) gap--;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic flush_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] random_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return ChZero + 8'(r);
    if (r < 16) return ChALower + 8'(r - 10);
    return ChAUpper + 8'(r - 16);
  endfunction

  function automatic logic [7:0] random_run_char();
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, 1) ? ChXLower : ChXUpper;
    return random_hex_digit();
  endfunction

  task automatic add_literal();
    int kind;
    kind = $urandom_range(0, 5);
    if (kind <= 2) begin
      text_buf.push_back(ChZero);
      text_buf.push_back($urandom_range(0, 1) ? ChXLower : ChXUpper);
    end
    case (kind)
      0: repeat (2) text_buf.push_back(random_hex_digit());
      1: text_buf.push_back(random_hex_digit());
      2: repeat ($urandom_range(0, 6)) text_buf.push_back(random_run_char());
      3: repeat ($urandom_range(1, 4)) text_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
      default: repeat ($urandom_range(1, 8)) text_buf.push_back(random_run_char());
    endcase
  endtask

  task automatic add_separator();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2: push_text(",");
      3, 4: push_text(", ");
      5: push_text(",\n  ");
      6: push_text("}");
      default: begin
        do c = 8'($urandom_range(0, 255)); while (is_run_char(c));
        text_buf.push_back(c);
      end
    endcase
  endtask

  task automatic build_array();
    logic [7:0] c;
    int n_lit;
    repeat ($urandom_range(0, 3)) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChLbrace);
      text_buf.push_back(c);
    end
    text_buf.push_back(ChLbrace);
    n_lit = $urandom_range(1, 12);
    for (int i = 0; i < n_lit; i++) begin
      add_literal();
      if (i != n_lit - 1 || $urandom_range(0, 4) != 0) add_separator();
    end
    if ($urandom_range(0, 1) == 1) push_text("};\n");
  endtask

  task automatic test_directed();
    push_text("{0xA5,0X,0xx7,}b");
    text_buf.push_back(8'h00);
    push_text("0x3456");
    text_buf.push_back(8'hFF);
    push_text("300");
    flush_text();
    push_text("z");
    flush_text();
    wait_drained();
  endtask

  task automatic test_random_arrays(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      build_array();
      flush_text();
    end
  endtask

  task automatic test_back_to_back();
    wait_drained();
    idle_pct = 0;
    test_random_arrays(200);
    idle_pct = 30;
  endtask

  task automatic test_output_hold();
    wait_drained();
    hold_left = HoldCycles;
    push_text("{");
    repeat (40) push_text("7,");
    flush_text();
    build_array();
    flush_text();
    wait_drained();
  endtask

  task automatic test_noise(input int count);
    logic [7:0] c;
    repeat (count) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 11) == 0) c = ChLbrace;
      send_char(c, $urandom_range(0, 29) == 0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_arrays(700);
    test_back_to_back();
    test_output_hold();
    test_noise(250);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== c_array_text_to_bytes.f =====
sv/ctb_pkg.sv
sv/ctb_decoder.sv
sv/c_array_text_to_bytes.sv
bench/c_array_text_to_bytes_test.sv
